[rtl/lac_pkg.sv]
// Shared types, codes and helper functions for the LAN address classifier.
// No dependencies; the files that use it refer to this package by scoped names.
`default_nettype none

package lac_pkg;

  // Table geometry
  localparam int MAX_LOCAL_NETS = 16;
  localparam int IDX_W = (MAX_LOCAL_NETS > 1) ? $clog2(MAX_LOCAL_NETS) : 1;
  localparam int CNT_W = $clog2(MAX_LOCAL_NETS + 1);
  localparam int LCNT_W = 5;

  // Request codes
  localparam logic REQ_QUERY = 1'b0;
  localparam logic REQ_LOAD  = 1'b1;

  // Address type codes
  localparam logic [1:0] ADDR_LOOPBACK = 2'd0;
  localparam logic [1:0] ADDR_IPV4     = 2'd1;
  localparam logic [1:0] ADDR_IPV6     = 2'd2;
  localparam logic [1:0] ADDR_OTHER    = 2'd3;

  // Match kind codes
  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_LOOPBACK = 2'd1;
  localparam logic [1:0] KIND_FIXED    = 2'd2;
  localparam logic [1:0] KIND_TABLE    = 2'd3;

  // Fixed private range octets
  localparam logic [7:0] OCT_TEN     = 8'd10;
  localparam logic [7:0] OCT_172     = 8'd172;
  localparam logic [7:0] OCT_16      = 8'd16;
  localparam logic [7:0] OCT_192     = 8'd192;
  localparam logic [7:0] OCT_168     = 8'd168;
  localparam logic [7:0] OCT_127     = 8'd127;
  localparam logic [7:0] MASK_F0     = 8'hf0;
  localparam logic [7:0] MASK_C0     = 8'hc0;
  localparam logic [7:0] MASK_FE     = 8'hfe;
  localparam logic [7:0] V6_LINK_B0  = 8'hfe;
  localparam logic [7:0] V6_LINK_B1  = 8'h80;
  localparam logic [7:0] V6_ULA_B0   = 8'hfc;

  typedef struct packed {
    logic        req_type;
    logic [1:0]  addr_type;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [63:0] mask_hi;
    logic [63:0] mask_lo;
    logic [3:0]  entry_index;
  } in_item_t;

  typedef struct packed {
    logic       is_lan;
    logic [1:0] match_kind;
  } out_item_t;

  // One stored local network entry
  typedef struct packed {
    logic [1:0]  net_type;
    logic [63:0] net_addr_hi;
    logic [63:0] net_addr_lo;
    logic [63:0] net_mask_hi;
    logic [63:0] net_mask_lo;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Table write request from the sequencer
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } ram_wr_t;

  // Fixed private ranges: IPv4 10/8, 172.16/12, 192.168/16, 127/8;
  // IPv6 fe80::/10, fc00::/7
  function automatic logic fixed_private(logic [1:0] atype, logic [63:0] hi,
                                         logic [63:0] lo);
    logic [7:0] o0;
    logic [7:0] o1;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       hit;
    o0  = lo[31:24];
    o1  = lo[23:16];
    b0  = hi[63:56];
    b1  = hi[55:48];
    hit = 1'b0;
    if (atype == ADDR_IPV4) begin
      hit = (o0 == OCT_TEN) ||
            ((o0 == OCT_172) && ((o1 & MASK_F0) == OCT_16)) ||
            ((o0 == OCT_192) && (o1 == OCT_168)) ||
            (o0 == OCT_127);
    end else if (atype == ADDR_IPV6) begin
      hit = ((b0 == V6_LINK_B0) && ((b1 & MASK_C0) == V6_LINK_B1)) ||
            ((b0 & MASK_FE) == V6_ULA_B0);
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

[rtl/lan_address_classifier_unit.sv]
// Top level of the LAN address classifier: count register, table RAM and
// request sequencer. Depends on lac_pkg, lac_net_ram and lac_scan_ctrl.
//
//  channel | direction | handshake              | payload
//  in_     | input     | in_valid / in_ready    | lac_pkg::in_item_t
//  out_    | output    | out_valid / out_ready  | lac_pkg::out_item_t
//  cfg_    | input     | cfg_valid / cfg_ready  | local_count, 5 bits
//
// A load or a loopback/fixed-range query passes through ST_DONE into the output register;
// in_ready rises again in the same cycle as out_valid.
// A query that scans the table compares up to n = min(local_count, 16) entries,
// fewer if an entry matches early; the single RAM read port paces the scan.
// One request is in flight at a time; the next is taken once the result sits
// in the output register, even while that result is stalled.
// Reset clears control state and local_count only; the table has no clearing pass.
`default_nettype none

module lan_address_classifier_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire lac_pkg::in_item_t            in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output lac_pkg::out_item_t                out_data,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [lac_pkg::LCNT_W-1:0]   cfg_local_count
);

  logic [lac_pkg::LCNT_W-1:0] local_count_r;
  logic [lac_pkg::CNT_W-1:0]  scan_n;
  lac_pkg::ram_wr_t           ram_wr;
  logic [lac_pkg::IDX_W-1:0]  ram_rd_addr;
  logic [lac_pkg::ENTRY_W-1:0] ram_rd_raw;

  assign cfg_ready = 1'b1;

  // Hold the entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      local_count_r <= cfg_local_count;
    end
  end

  // Clamp the scan length to the table depth
  assign scan_n = (int'(local_count_r) > lac_pkg::MAX_LOCAL_NETS) ?
                  lac_pkg::CNT_W'(lac_pkg::MAX_LOCAL_NETS) :
                  lac_pkg::CNT_W'(local_count_r);

  lac_net_ram #(
    .DATA_W (lac_pkg::ENTRY_W),
    .DEPTH  (lac_pkg::MAX_LOCAL_NETS),
    .ADDR_W (lac_pkg::IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr.en),
    .wr_addr (ram_wr.addr),
    .wr_data (ram_wr.data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_raw)
  );

  lac_scan_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .scan_n      (scan_n),
    .ram_wr      (ram_wr),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (lac_pkg::entry_t'(ram_rd_raw)),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

[rtl/lac_net_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; used by the classifier to hold the local network table.
`default_nettype none

module lac_net_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[rtl/lac_scan_ctrl.sv]
// Request sequencer: loads table entries, runs fixed range checks and scans
// the table one entry per cycle. Depends on lac_pkg.
`default_nettype none

module lac_scan_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire lac_pkg::in_item_t           in_data,
  input  wire logic [lac_pkg::CNT_W-1:0]   scan_n,
  output lac_pkg::ram_wr_t                 ram_wr,
  output logic      [lac_pkg::IDX_W-1:0]   ram_rd_addr,
  input  wire lac_pkg::entry_t             ram_rd_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output lac_pkg::out_item_t               out_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t                    state_r, state_nxt;
  logic [lac_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]                q_type_r;
  logic [63:0]               q_hi_r;
  logic [63:0]               q_lo_r;
  lac_pkg::out_item_t        res_r, res_nxt;
  logic                      out_valid_r, out_valid_nxt;
  lac_pkg::out_item_t        out_data_r, out_data_nxt;
  logic                      accept;
  logic                      entry_hit;
  logic                      scan_last;
  logic [lac_pkg::CNT_W-1:0] cnt_inc;
  logic [31:0]               v4_mask;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Write a table entry on an accepted load
  always_comb begin
    ram_wr.en                  = accept && (in_data.req_type == lac_pkg::REQ_LOAD) &&
                                 (int'(in_data.entry_index) < lac_pkg::MAX_LOCAL_NETS);
    ram_wr.addr                = lac_pkg::IDX_W'(in_data.entry_index);
    ram_wr.data.net_type       = in_data.addr_type;
    ram_wr.data.net_addr_hi    = in_data.addr_hi;
    ram_wr.data.net_addr_lo    = in_data.addr_lo;
    ram_wr.data.net_mask_hi    = in_data.mask_hi;
    ram_wr.data.net_mask_lo    = in_data.mask_lo;
  end

  // Read entry 0 on accept, then one entry ahead of the compare
  assign cnt_inc     = cnt_r + 1'b1;
  assign ram_rd_addr = (state_r == ST_SCAN) ? cnt_inc[lac_pkg::IDX_W-1:0]
                                            : '0;
  assign scan_last   = (cnt_inc == scan_n);

  // Compare the entry read last cycle against the held query
  assign v4_mask = ram_rd_data.net_mask_lo[31:0];
  always_comb begin
    entry_hit = 1'b0;
    if (ram_rd_data.net_type == q_type_r) begin
      case (q_type_r)
        lac_pkg::ADDR_IPV4: begin
          entry_hit = ((ram_rd_data.net_addr_lo[31:0] & v4_mask) ==
                       (q_lo_r[31:0] & v4_mask));
        end
        lac_pkg::ADDR_IPV6: begin
          entry_hit = ((ram_rd_data.net_addr_hi & ram_rd_data.net_mask_hi) ==
                       (q_hi_r & ram_rd_data.net_mask_hi)) &&
                      ((ram_rd_data.net_addr_lo & ram_rd_data.net_mask_lo) ==
                       (q_lo_r & ram_rd_data.net_mask_lo));
        end
        lac_pkg::ADDR_OTHER: begin
          entry_hit = 1'b1;
        end
        default: begin
          entry_hit = 1'b0;
        end
      endcase
    end
  end

  // Next state, result and output register
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
          res_nxt   = '{is_lan: 1'b0, match_kind: lac_pkg::KIND_NONE};
          if (in_data.req_type == lac_pkg::REQ_QUERY) begin
            if (in_data.addr_type == lac_pkg::ADDR_LOOPBACK) begin
              res_nxt = '{is_lan: 1'b1, match_kind: lac_pkg::KIND_LOOPBACK};
            end else if (lac_pkg::fixed_private(in_data.addr_type, in_data.addr_hi,
                                                in_data.addr_lo)) begin
              res_nxt = '{is_lan: 1'b1, match_kind: lac_pkg::KIND_FIXED};
            end else if (scan_n != '0) begin
              state_nxt = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_inc;
        if (entry_hit) begin
          res_nxt   = '{is_lan: 1'b1, match_kind: lac_pkg::KIND_TABLE};
          state_nxt = ST_DONE;
        end else if (scan_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state, counters and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // Capture the query address
  always_ff @(posedge clk) begin
    if (accept) begin
      q_type_r <= in_data.addr_type;
      q_hi_r   <= in_data.addr_hi;
      q_lo_r   <= in_data.addr_lo;
    end
  end

endmodule

`default_nettype wire

[rtl/lac_checker.sv]
// Port-level checker for the LAN address classifier, bound to the top level.
// Depends on lac_pkg and lan_address_classifier_unit.
`default_nettype none

module lac_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire lac_pkg::out_item_t out_data
);

  logic [1:0] pend_r, pend_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Track requests accepted but not yet answered
  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 2'd1;
    end else if (!in_acc && out_acc) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // No result without an outstanding request
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without a request");

  // At most one request in work plus one waiting result
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many requests outstanding");

  // is_lan agrees with the match kind
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.is_lan == (out_data.match_kind != lac_pkg::KIND_NONE)))
    else $error("is_lan and match_kind disagree");

endmodule

bind lan_address_classifier_unit lac_checker u_lac_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
